FILE: rtl/acsc_pkg.sv
// shared types and constants of the adaptive chunk size controller
// no dependencies; imported by every other file of the block
`default_nettype none

package acsc_pkg;

	// field widths of the request and result items
	localparam int unsigned OP_W     = 2;
	localparam int unsigned BYTES_W  = 32;
	localparam int unsigned ACK_W    = 24;
	localparam int unsigned REM_W    = 48;
	localparam int unsigned SIZE_W   = 32;
	localparam int unsigned AVGA_W   = 32;
	localparam int unsigned AVGR_W   = 56;
	localparam int unsigned CNTO_W   = 32;
	localparam int unsigned CFG_W    = 32;
	localparam int unsigned CFGIDX_W = 3;
	localparam int unsigned IN_DATA_W  = 104;
	localparam int unsigned OUT_DATA_W = 280;

	// default parameter values
	localparam int unsigned COUNT_BITS_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF  = 8;

	// ewma weights in q0.16: alpha 0.2 and one minus alpha
	localparam logic [16:0] ALPHA_Q16  = 17'd13107;
	localparam logic [16:0] BETA_Q16   = 17'd52429;
	localparam int unsigned ROUND_HALF = 32768;

	// bytes per ms to bytes per s
	localparam logic [9:0]  RATE_SCALE = 10'd1000;
	localparam int unsigned PROD_W     = BYTES_W + 10;

	localparam logic [SIZE_W-1:0] MIN_STEP       = 32'd16384;
	localparam logic [SIZE_W-1:0] DEFAULT_MIN    = 32'd32768;
	localparam logic [ACK_W-1:0]  DEFAULT_TARGET = 24'd700;

	// register reset values
	localparam logic              RST_ENABLE = 1'b1;
	localparam logic [CFG_W-1:0]  RST_MIN    = 32'd32768;
	localparam logic [CFG_W-1:0]  RST_MAX    = 32'd8388608;
	localparam logic [CFG_W-1:0]  RST_INIT   = 32'd1048576;
	localparam logic [ACK_W-1:0]  RST_TARGET = 24'd700;
	// normalized initial size clamped with the reset range
	localparam logic [SIZE_W-1:0] RST_SIZE   = 32'd1048576;

	// multiply-accumulate steps of the two ewma updates
	localparam int unsigned MAC_STEPS  = 8;
	localparam int unsigned MACSTEP_W  = 4;

	typedef enum logic [OP_W-1:0] {
		OP_SUCCESS = 2'd0,
		OP_FAILURE = 2'd1,
		OP_SUGGEST = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [CFGIDX_W-1:0] {
		REG_ENABLE = 3'd0,
		REG_MIN    = 3'd1,
		REG_MAX    = 3'd2,
		REG_INIT   = 3'd3,
		REG_TARGET = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIVGO,
		ST_DIV,
		ST_MAC,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load_in;
		logic       mul;
		logic       div_start;
		logic       mac_issue;
		logic [2:0] mac_step;
		logic       commit;
		logic       emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic long_op;
		logic div_done;
		logic seed;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/adaptive_chunk_size_controller.sv
// top level of the adaptive chunk size controller (aimd window with ewma)
// depends on acsc_pkg, acsc_ctrl, acsc_dp and acsc_div
//
// usage
//   s_* takes one request per handshake: s_tuser selects success, failure,
//   suggest or no-op, s_tdata carries bytes sent, ack time and remaining
//   bytes. each request returns exactly one result on m_*, a full snapshot
//   of chunk size, suggestion, ack and rate averages and the four counters.
//   settings are written through cfg_we/cfg_index/cfg_data while idle.
// sequencing
//   one request at a time. failure, suggest, no-op and successes that change
//   nothing go straight to commit and result. an adapting success first runs
//   the serial divider for the rate sample, one quotient bit per cycle over
//   42 + FRAC_BITS bits, then the shared 17x32 multiply-accumulate for the
//   ewma updates, skipped by the seeding success.
// reset
//   arst_n clears the sequencer, loads the register defaults and sets the
//   chunk size to 1 MiB with zeroed averages and counters.
// stalls
//   the result sits in its own register; s_tready returns once the result
//   is parked, so a new request is taken while m_tready is low. a second
//   result then waits in the sequencer until the first one is taken.
`default_nettype none

module adaptive_chunk_size_controller
	import acsc_pkg::*;
#(
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFGIDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	// request channel
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// bytes_sent[31:0], ack_ms[55:32], remaining_bytes[103:56]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// operation[1:0]
	input  wire logic [OP_W-1:0]       s_tuser,
	// result channel
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// chunk_size[31:0], suggested_size[63:32], ewma_ack[95:64],
	// ewma_rate[151:96], success_total[183:152], failure_total[215:184],
	// success_run[247:216], failure_run[279:248]
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	cmd_t cmd;
	sts_t sts;

	logic [SIZE_W-1:0] chunk_size, suggested_size;
	logic [AVGA_W-1:0] ewma_ack;
	logic [AVGR_W-1:0] ewma_rate;
	logic [CNTO_W-1:0] success_total, failure_total, success_run, failure_run;

	// sequencer: owns request and result handshakes
	acsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// datapath: settings, state, divider, mac and result register
	acsc_dp #(
		.COUNT_BITS(COUNT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_op         (s_tuser),
		.in_bytes      (s_tdata[31:0]),
		.in_ack        (s_tdata[55:32]),
		.in_rem        (s_tdata[103:56]),
		.cmd           (cmd),
		.sts           (sts),
		.chunk_size    (chunk_size),
		.suggested_size(suggested_size),
		.ewma_ack      (ewma_ack),
		.ewma_rate     (ewma_rate),
		.success_total (success_total),
		.failure_total (failure_total),
		.success_run   (success_run),
		.failure_run   (failure_run)
	);

	// result packing, highest field first
	assign m_tdata = {failure_run, success_run, failure_total, success_total,
	                  ewma_rate, ewma_ack, suggested_size, chunk_size};

endmodule

`default_nettype wire

FILE: rtl/acsc_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on acsc_pkg
`default_nettype none

module acsc_div
	import acsc_pkg::*;
#(
	parameter int unsigned DW = 50,
	parameter int unsigned VW = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      quotient
);

	localparam int unsigned CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/acsc_dp.sv
// datapath: settings, chunk size, ewma averages, counters, result register
// depends on acsc_pkg and acsc_div
`default_nettype none

module acsc_dp
	import acsc_pkg::*;
#(
	parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFGIDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]    cfg_data,
	input  wire logic [OP_W-1:0]     in_op,
	input  wire logic [BYTES_W-1:0]  in_bytes,
	input  wire logic [ACK_W-1:0]    in_ack,
	input  wire logic [REM_W-1:0]    in_rem,
	input  wire cmd_t                cmd,
	output sts_t                     sts,
	output logic [SIZE_W-1:0]        chunk_size,
	output logic [SIZE_W-1:0]        suggested_size,
	output logic [AVGA_W-1:0]        ewma_ack,
	output logic [AVGR_W-1:0]        ewma_rate,
	output logic [CNTO_W-1:0]        success_total,
	output logic [CNTO_W-1:0]        failure_total,
	output logic [CNTO_W-1:0]        success_run,
	output logic [CNTO_W-1:0]        failure_run
);

	localparam int unsigned DIVW  = PROD_W + FRAC_BITS;
	localparam int unsigned ACC_W = 73;
	localparam int unsigned PR_W  = 49;

	// settings, raw as written
	logic              en_q;
	logic [CFG_W-1:0]  min_q, max_q, init_q;
	logic [ACK_W-1:0]  tgt_q;

	// adaptive state
	logic [SIZE_W-1:0]     size_q;
	logic [AVGA_W-1:0]     avg_ack_q;
	logic [AVGR_W-1:0]     avg_rate_q;
	logic [COUNT_BITS-1:0] ok_cnt_q, fail_cnt_q, ok_run_q, fail_run_q;

	// request being worked on
	op_t                op_q;
	logic               go_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [ACK_W-1:0]   ack_q;
	logic [REM_W-1:0]   rem_q;
	logic [PROD_W-1:0]  prod_q;
	logic [AVGA_W-1:0]  ack_smp_q;
	logic [AVGR_W-1:0]  rate_smp_q;
	logic [AVGA_W-1:0]  ack_new_q;
	logic [AVGR_W-1:0]  rate_new_q;
	logic [SIZE_W-1:0]  sugg_q;

	// mac pipeline
	logic [PR_W-1:0]  prod_s1;
	logic             pv_s1, hi_s1, last_s1, rsel_s1;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] acc_sum;
	logic [16:0]      mac_coef;
	logic [31:0]      mac_chunk;

	logic [SIZE_W-1:0] eff_min, eff_max;
	logic [ACK_W-1:0]  eff_tgt;
	logic [ACK_W-1:0]  in_ack_eff;
	logic [DIVW-1:0]   dividend;
	logic [DIVW-1:0]   quotient;
	logic              div_done;
	logic [63:0]       ack_ext, quo_ext;
	logic [SIZE_W:0]   grow_sz, step_sz;
	logic [SIZE_W+2:0] seven_sz;
	logic [SIZE_W:0]   next_sz;
	logic [SIZE_W-1:0] sugg_raw;

	function automatic logic [SIZE_W-1:0] clamp_sz(input logic [SIZE_W:0] v,
		input logic [SIZE_W-1:0] lo, input logic [SIZE_W-1:0] hi);
		logic [SIZE_W-1:0] r;
		if (v < {1'b0, lo}) r = lo;
		else if (v > {1'b0, hi}) r = hi;
		else r = v[SIZE_W-1:0];
		return r;
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
		return (&c) ? c : c + COUNT_BITS'(1);
	endfunction

	assign eff_min    = (min_q == '0) ? DEFAULT_MIN : min_q;
	assign eff_max    = (max_q < eff_min) ? eff_min : max_q;
	assign eff_tgt    = (tgt_q == '0) ? DEFAULT_TARGET : tgt_q;
	assign in_ack_eff = (in_ack == '0) ? ACK_W'(1) : in_ack;

	assign sts.long_op  = (op_t'(in_op) == OP_SUCCESS) && (in_bytes != '0) && en_q;
	assign sts.div_done = div_done;
	assign sts.seed     = (ok_cnt_q == '0);

	// settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= RST_ENABLE;
			min_q  <= RST_MIN;
			max_q  <= RST_MAX;
			init_q <= RST_INIT;
			tgt_q  <= RST_TARGET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_ENABLE: en_q   <= cfg_data[0];
				REG_MIN:    min_q  <= cfg_data;
				REG_MAX:    max_q  <= cfg_data;
				REG_INIT:   init_q <= cfg_data;
				REG_TARGET: tgt_q  <= cfg_data[ACK_W-1:0];
				default: ;
			endcase
		end
	end

	// rate sample divider
	assign dividend = DIVW'(prod_q) << FRAC_BITS;

	acsc_div #(
		.DW(DIVW),
		.VW(ACK_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dividend),
		.divisor (ack_q),
		.done    (div_done),
		.quotient(quotient)
	);

	assign ack_ext = 64'(ack_q) << FRAC_BITS;
	assign quo_ext = 64'(quotient);

	// request capture, product and samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q <= 1'b0;
			op_q <= OP_NONE;
		end else if (cmd.load_in) begin
			go_q <= sts.long_op;
			op_q <= op_t'(in_op);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			bytes_q <= in_bytes;
			ack_q   <= in_ack_eff;
			rem_q   <= in_rem;
		end
		if (cmd.mul) begin
			prod_q    <= PROD_W'(bytes_q) * PROD_W'(RATE_SCALE);
			ack_smp_q <= (|ack_ext[63:32]) ? '1 : ack_ext[31:0];
		end
		if (div_done) begin
			rate_smp_q <= (|quo_ext[63:56]) ? '1 : quo_ext[55:0];
		end
	end

	// ewma multiply-accumulate: step bit 2 picks the average, bit 1 the
	// weight and old value, bit 0 the upper half of the operand
	always_comb begin
		mac_coef = cmd.mac_step[1] ? BETA_Q16 : ALPHA_Q16;
		case (cmd.mac_step[2:0])
			3'd0:    mac_chunk = ack_smp_q;
			3'd2:    mac_chunk = avg_ack_q;
			3'd4:    mac_chunk = rate_smp_q[31:0];
			3'd5:    mac_chunk = 32'(rate_smp_q[AVGR_W-1:32]);
			3'd6:    mac_chunk = avg_rate_q[31:0];
			3'd7:    mac_chunk = 32'(avg_rate_q[AVGR_W-1:32]);
			default: mac_chunk = '0;
		endcase
	end

	assign acc_sum = acc_q + (hi_s1 ? ACC_W'({prod_s1, 32'd0}) : ACC_W'(prod_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.mac_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_issue) begin
			prod_s1 <= PR_W'(mac_coef) * PR_W'(mac_chunk);
			hi_s1   <= cmd.mac_step[0];
			last_s1 <= cmd.mac_step[1] & cmd.mac_step[0];
			rsel_s1 <= cmd.mac_step[2];
		end
		if (cmd.mul) begin
			acc_q <= ACC_W'(ROUND_HALF);
		end else if (pv_s1) begin
			if (last_s1) begin
				acc_q <= ACC_W'(ROUND_HALF);
				if (rsel_s1) rate_new_q <= acc_sum[16 +: AVGR_W];
				else         ack_new_q  <= acc_sum[16 +: AVGA_W];
			end else begin
				acc_q <= acc_sum;
			end
		end
	end

	// next chunk size of a success
	assign step_sz  = ((size_q >> 3) < MIN_STEP) ? (SIZE_W+1)'(MIN_STEP)
	                                             : (SIZE_W+1)'(size_q >> 3);
	assign grow_sz  = (SIZE_W+1)'(size_q) + step_sz;
	assign seven_sz = ((SIZE_W+3)'(size_q) << 3) - (SIZE_W+3)'(size_q);

	always_comb begin
		if (ack_q <= eff_tgt) begin
			next_sz = grow_sz;
		end else if ((ACK_W+1)'(ack_q) >= {eff_tgt, 1'b0}) begin
			next_sz = (SIZE_W+1)'(size_q >> 1);
		end else begin
			next_sz = (SIZE_W+1)'(seven_sz >> 3);
		end
	end

	// suggest query: a remaining count below the minimum passes unclamped
	always_comb begin
		if ((rem_q != '0) && (rem_q < REM_W'(eff_min))) begin
			sugg_raw = rem_q[SIZE_W-1:0];
		end else if ((rem_q != '0) && (rem_q < REM_W'(size_q))) begin
			sugg_raw = clamp_sz((SIZE_W+1)'(rem_q[SIZE_W-1:0]), eff_min, eff_max);
		end else begin
			sugg_raw = clamp_sz((SIZE_W+1)'(size_q), eff_min, eff_max);
		end
	end

	// adaptive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= RST_SIZE;
			avg_ack_q  <= '0;
			avg_rate_q <= '0;
			ok_cnt_q   <= '0;
			fail_cnt_q <= '0;
			ok_run_q   <= '0;
			fail_run_q <= '0;
		end else if (cfg_we && (cfg_idx_t'(cfg_index) == REG_INIT)) begin
			size_q <= clamp_sz((SIZE_W+1)'((cfg_data == '0) ? eff_min : cfg_data),
			                   eff_min, eff_max);
		end else if (cmd.commit) begin
			if (op_q == OP_SUCCESS && go_q) begin
				avg_ack_q  <= sts.seed ? ack_smp_q : ack_new_q;
				avg_rate_q <= sts.seed ? rate_smp_q : rate_new_q;
				ok_cnt_q   <= sat_inc(ok_cnt_q);
				ok_run_q   <= sat_inc(ok_run_q);
				fail_run_q <= '0;
				size_q     <= clamp_sz(next_sz, eff_min, eff_max);
			end else if (op_q == OP_FAILURE && en_q) begin
				fail_cnt_q <= sat_inc(fail_cnt_q);
				fail_run_q <= sat_inc(fail_run_q);
				ok_run_q   <= '0;
				size_q     <= clamp_sz((SIZE_W+1)'(size_q >> 1), eff_min, eff_max);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			sugg_q <= (op_q == OP_SUGGEST) ? sugg_raw : '0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			chunk_size     <= size_q;
			suggested_size <= sugg_q;
			ewma_ack       <= avg_ack_q;
			ewma_rate      <= avg_rate_q;
			success_total  <= CNTO_W'(ok_cnt_q);
			failure_total  <= CNTO_W'(fail_cnt_q);
			success_run    <= CNTO_W'(ok_run_q);
			failure_run    <= CNTO_W'(fail_run_q);
		end
	end

	a_fail_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (op_q == OP_FAILURE) && en_q |=> fail_run_q != '0)
		else $error("failure run still zero after a failure");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (go_q || ((op_q == OP_FAILURE) && en_q))
		|=> (size_q >= eff_min) && (size_q <= eff_max))
		else $error("chunk size out of range after an update");

	a_seed_path: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && go_q |-> $past(ok_cnt_q) == ok_cnt_q)
		else $error("counter moved before the update was committed");

endmodule

`default_nettype wire

FILE: rtl/acsc_ctrl.sv
// sequencer of the chunk controller: request intake, divide, ewma steps,
// commit and result handoff; depends on acsc_pkg
`default_nettype none

module acsc_ctrl
	import acsc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t               state_q, state_d;
	logic [MACSTEP_W-1:0] step_q;
	logic                 m_valid_q;
	logic                 accept;
	logic                 out_free;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = sts.long_op ? ST_MUL : ST_COMMIT;
			ST_MUL:    state_d = ST_DIVGO;
			ST_DIVGO:  state_d = ST_DIV;
			ST_DIV:    if (sts.div_done) state_d = sts.seed ? ST_COMMIT : ST_MAC;
			ST_MAC:    if (step_q == MACSTEP_W'(MAC_STEPS)) state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_EMIT;
			ST_EMIT:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == ST_IDLE);
		cmd.load_in   = accept;
		cmd.mul       = (state_q == ST_MUL);
		cmd.div_start = (state_q == ST_DIVGO);
		cmd.mac_issue = (state_q == ST_MAC) && (step_q < MACSTEP_W'(MAC_STEPS));
		cmd.mac_step  = step_q[2:0];
		cmd.commit    = (state_q == ST_COMMIT);
		cmd.emit      = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MAC) step_q <= step_q + MACSTEP_W'(1);
			else                   step_q <= '0;
			if (cmd.emit)      m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request taken while the previous one is in work");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its wait state");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && out_free |=> m_tvalid)
		else $error("result not presented after handoff");

endmodule

`default_nettype wire
